FILE: design/tac_pkg.sv
// Package: shared widths, register map and clamp mode codes of the texel clamp unit
package tac_pkg;

  // channel format: signed fixed point, fixed 24-bit width
  localparam int unsigned ChW = 24;
  localparam int unsigned FractionBitsDef = 8;

  // configuration port geometry
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  typedef logic signed [ChW-1:0] chan_t;

  // register index, taken from byte address bits [4:2]
  typedef enum logic [2:0] {
    REG_AMB_RED    = 3'd0,
    REG_AMB_GREEN  = 3'd1,
    REG_AMB_BLUE   = 3'd2,
    REG_AMB_ENABLE = 3'd3,
    REG_CLAMP_MODE = 3'd4
  } reg_idx_e;

  // clamp modes; the unused code behaves as pass-through
  typedef enum logic [1:0] {
    CLAMP_PASS  = 2'd0,
    CLAMP_SAT   = 2'd1,
    CLAMP_RATIO = 2'd2
  } clamp_mode_e;

endpackage

FILE: design/tac_in_if.sv
// Interface: input texel channel with valid/ready handshake
interface tac_in_if;
  logic           valid;
  logic           ready;
  tac_pkg::chan_t red_in;
  tac_pkg::chan_t green_in;
  tac_pkg::chan_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: design/tac_out_if.sv
// Interface: output texel channel with valid/ready handshake
interface tac_out_if;
  logic           valid;
  logic           ready;
  tac_pkg::chan_t red_out;
  tac_pkg::chan_t green_out;
  tac_pkg::chan_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

FILE: design/texel_ambient_clamp_unit.sv
// Texel ambient add and clamp unit: config registers, ambient stage and divider pipeline
// Stages: ambient add, largest channel, divider set-up, one per quotient bit, output register.
// Throughput: one texel per cycle while the output is ready; depth set by the ratio divider.
// Stalls: each stage holds its item while the next one is full and stalled; bubbles collapse.
// Reset: asynchronous, active low; clears stage valid bits, ambient 0 and off, clamp mode 1.
module texel_ambient_clamp_unit #(
  parameter int unsigned FRACTION_BITS = tac_pkg::FractionBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tac_in_if.sink                        tex_i,
  tac_out_if.source                     tex_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tac_pkg::ApbAddrW-1:0]  paddr,
  input  logic [tac_pkg::ApbDataW-1:0]  pwdata,
  output logic [tac_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned ChW  = tac_pkg::ChW;
  localparam int unsigned MW   = ChW - 1;              // magnitude of a non-negative channel
  localparam int unsigned QW   = 8 + FRACTION_BITS;    // quotient width, holds 255.0
  localparam int unsigned PW   = MW + 8;               // channel times 255
  localparam int unsigned TopW = ChW + 2;
  localparam int unsigned NS   = QW + 4;               // ambient, max, divider init+steps, out
  localparam int unsigned DW   = tac_pkg::ApbDataW;
  localparam logic signed [TopW-1:0] Top = TopW'(255 << FRACTION_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  tac_pkg::chan_t amb_red_q, amb_green_q, amb_blue_q;
  logic           amb_en_q;
  logic [1:0]     mode_q;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // write a register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_red_q   <= '0;
      amb_green_q <= '0;
      amb_blue_q  <= '0;
      amb_en_q    <= 1'b0;
      mode_q      <= tac_pkg::CLAMP_SAT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tac_pkg::REG_AMB_RED:    amb_red_q   <= pwdata[ChW-1:0];
        tac_pkg::REG_AMB_GREEN:  amb_green_q <= pwdata[ChW-1:0];
        tac_pkg::REG_AMB_BLUE:   amb_blue_q  <= pwdata[ChW-1:0];
        tac_pkg::REG_AMB_ENABLE: amb_en_q    <= pwdata[0];
        tac_pkg::REG_CLAMP_MODE: mode_q      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    case (cfg_idx)
      tac_pkg::REG_AMB_RED:    prdata = {{(DW-ChW){1'b0}}, amb_red_q};
      tac_pkg::REG_AMB_GREEN:  prdata = {{(DW-ChW){1'b0}}, amb_green_q};
      tac_pkg::REG_AMB_BLUE:   prdata = {{(DW-ChW){1'b0}}, amb_blue_q};
      tac_pkg::REG_AMB_ENABLE: prdata = {{(DW-1){1'b0}}, amb_en_q};
      tac_pkg::REG_CLAMP_MODE: prdata = {{(DW-2){1'b0}}, mode_q};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its item moves on
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = tex_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign tex_i.ready = rdy[0];
  assign tex_o.valid = vld_q[NS-1];

  // advance valid bits with their items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= tex_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel views of the ports and registers
  // ---------------------------------------------------------------------------
  tac_pkg::chan_t in_ch  [3];
  tac_pkg::chan_t amb_ch [3];
  tac_pkg::chan_t out_q  [3];

  assign in_ch[0]  = tex_i.red_in;
  assign in_ch[1]  = tex_i.green_in;
  assign in_ch[2]  = tex_i.blue_in;
  assign amb_ch[0] = amb_red_q;
  assign amb_ch[1] = amb_green_q;
  assign amb_ch[2] = amb_blue_q;

  assign tex_o.red_out   = out_q[0];
  assign tex_o.green_out = out_q[1];
  assign tex_o.blue_out  = out_q[2];

  // ---------------------------------------------------------------------------
  // Stage 0: ambient add with saturation
  // ---------------------------------------------------------------------------
  tac_pkg::chan_t s0_ch_q [3];

  for (genvar g = 0; g < 3; g++) begin : g_amb
    logic signed [ChW:0] sum;
    tac_pkg::chan_t      sat;

    assign sum = {in_ch[g][ChW-1], in_ch[g]} + {amb_ch[g][ChW-1], amb_ch[g]};

    // clip to the channel range when the sign bits disagree
    always_comb begin
      if (sum[ChW] != sum[ChW-1]) begin
        sat = sum[ChW] ? {1'b1, {(ChW-1){1'b0}}} : {1'b0, {(ChW-1){1'b1}}};
      end else begin
        sat = sum[ChW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        s0_ch_q[g] <= amb_en_q ? sat : in_ch[g];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: largest channel
  // ---------------------------------------------------------------------------
  tac_pkg::chan_t s1_ch_q [3];
  tac_pkg::chan_t s1_max_q;
  tac_pkg::chan_t max01;
  tac_pkg::chan_t max012;

  assign max01  = (s0_ch_q[1] > s0_ch_q[0]) ? s0_ch_q[1] : s0_ch_q[0];
  assign max012 = (s0_ch_q[2] > max01) ? s0_ch_q[2] : max01;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_ch_q  <= s0_ch_q;
      s1_max_q <= max012;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline: entry j holds the item after j quotient bits
  // ---------------------------------------------------------------------------
  logic [MW-1:0]  dv_rem_q [QW+1][3];
  logic [QW-1:0]  dv_quo_q [QW+1][3];
  logic [7:0]     dv_lo_q  [QW+1][3];
  tac_pkg::chan_t dv_alt_q [QW+1][3];
  logic           dv_sel_q [QW+1][3];
  logic [MW-1:0]  dv_m_q   [QW+1];

  logic signed [TopW-1:0] max_ext;
  logic                   ratio_mode;
  logic                   over_top;

  assign max_ext    = TopW'(s1_max_q);
  assign ratio_mode = (mode_q == tac_pkg::CLAMP_RATIO);
  assign over_top   = ratio_mode && (max_ext > Top);

  // Stage 2: pick the non-divided result and set up the dividend c*255 << FRACTION_BITS
  for (genvar g = 0; g < 3; g++) begin : g_init
    logic signed [TopW-1:0] c_ext;
    logic [PW-1:0]          prod;
    tac_pkg::chan_t         alt;

    assign c_ext = TopW'(s1_ch_q[g]);
    assign prod  = (PW'(s1_ch_q[g][MW-1:0]) << 8) - PW'(s1_ch_q[g][MW-1:0]);

    always_comb begin
      if (mode_q == tac_pkg::CLAMP_SAT) begin
        if (c_ext > Top) begin
          alt = Top[ChW-1:0];
        end else if (s1_ch_q[g][ChW-1]) begin
          alt = '0;
        end else begin
          alt = s1_ch_q[g];
        end
      end else if (ratio_mode) begin
        alt = s1_ch_q[g][ChW-1] ? '0 : s1_ch_q[g];
      end else begin
        alt = s1_ch_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[2]) begin
        dv_rem_q[0][g] <= prod[PW-1:8];
        dv_lo_q[0][g]  <= prod[7:0];
        dv_quo_q[0][g] <= '0;
        dv_alt_q[0][g] <= alt;
        dv_sel_q[0][g] <= over_top && !s1_ch_q[g][ChW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      dv_m_q[0] <= s1_max_q[MW-1:0];
    end
  end

  // one restoring step per stage: bring down a dividend bit, subtract when it fits
  for (genvar j = 1; j <= QW; j++) begin : g_div
    for (genvar g = 0; g < 3; g++) begin : g_ch
      logic [MW:0] trial;
      logic [MW:0] diff;
      logic        take;

      assign trial = {dv_rem_q[j-1][g], dv_lo_q[j-1][g][7]};
      assign diff  = trial - {1'b0, dv_m_q[j-1]};
      assign take  = (trial >= {1'b0, dv_m_q[j-1]});

      always_ff @(posedge clk_i) begin
        if (rdy[j+2]) begin
          dv_rem_q[j][g] <= take ? diff[MW-1:0] : trial[MW-1:0];
          dv_quo_q[j][g] <= {dv_quo_q[j-1][g][QW-2:0], take};
          dv_lo_q[j][g]  <= {dv_lo_q[j-1][g][6:0], 1'b0};
          dv_alt_q[j][g] <= dv_alt_q[j-1][g];
          dv_sel_q[j][g] <= dv_sel_q[j-1][g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+2]) begin
        dv_m_q[j] <= dv_m_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: scaled channel or the non-divided result
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < 3; g++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (rdy[NS-1]) begin
        out_q[g] <= dv_sel_q[QW][g] ? ChW'(dv_quo_q[QW][g]) : dv_alt_q[QW][g];
      end
    end
  end

endmodule
